[rtl/tcw_pkg.sv]
// ============================================================================
// tcw_pkg: shared types and constants of the text console writer
// Beat layouts, command codes and character constants used by all modules but tcw_ram.
// ============================================================================
`default_nettype none

package tcw_pkg;

    localparam int unsigned DEF_COLUMNS = 80;
    localparam int unsigned DEF_ROWS    = 25;

    localparam int unsigned KIND_W       = 2;
    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned CELL_INDEX_W = 11;
    localparam int unsigned OFFSET_W     = 11;
    localparam int unsigned CELL_W       = 16;
    localparam int unsigned COLOR_W      = 4;
    localparam int unsigned CFG_INDEX_W  = 1;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned TAB_STEP     = 4;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PRINT_END = 8'd127;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

    localparam int unsigned OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
    localparam logic [OP_W-1:0] OP_PRINT   = 3'd1;
    localparam logic [OP_W-1:0] OP_NEWLINE = 3'd2;
    localparam logic [OP_W-1:0] OP_RETURN  = 3'd3;
    localparam logic [OP_W-1:0] OP_TAB     = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ    = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_item;

    typedef struct packed {
        logic [OFFSET_W-1:0] cursor_offset;
        logic [CELL_W-1:0]   cell_value;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/tcw_ram.sv]
// ============================================================================
// tcw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/tcw_front.sv]
// ============================================================================
// tcw_front: input acceptance and classification
// Decodes each input beat into a command and pushes it into the queue.
// ============================================================================
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire logic  i_in_valid,
    input  wire t_item i_item,
    input  wire logic  i_q_full,
    input  wire logic  i_engine_ready,
    output logic       o_in_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic w_printable;

    assign o_in_stall  = i_q_full || !i_engine_ready;
    assign o_push      = i_in_valid && !o_in_stall;
    assign w_printable = (i_item.char_code >= CH_PRINT_LO) && (i_item.char_code < CH_PRINT_END);

    always_comb begin
        o_cmd.char_code  = i_item.char_code;
        o_cmd.cell_index = i_item.cell_index;
        unique case (i_item.kind)
            KIND_PUT: begin
                if (i_item.char_code == CH_NEWLINE) begin
                    o_cmd.op = OP_NEWLINE;
                end else if (i_item.char_code == CH_RETURN) begin
                    o_cmd.op = OP_RETURN;
                end else if (i_item.char_code == CH_TAB) begin
                    o_cmd.op = OP_TAB;
                end else if (w_printable) begin
                    o_cmd.op = OP_PRINT;
                end else begin
                    o_cmd.op = OP_NOP;
                end
            end
            KIND_CLEAR: begin
                o_cmd.op = OP_CLEAR;
            end
            KIND_READ: begin
                o_cmd.op = OP_READ;
            end
            default: begin
                o_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/tcw_queue.sv]
// ============================================================================
// tcw_queue: command queue between front and back
// A small FIFO that lets either side stall on its own.
// ============================================================================
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CNTW-1:0] r_count;
    logic [PW-1:0]   n_wptr;
    logic [PW-1:0]   n_rptr;
    logic [CNTW-1:0] n_count;

    assign o_full  = (r_count == CNTW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/tcw_back.sv]
// ============================================================================
// tcw_back: command execution engine
// Owns the cursor, the cell store and the result register; runs put, read,
// clear, scroll and the clearing pass after reset.
// ============================================================================
`default_nettype none

module tcw_back
    import tcw_pkg::*;
#(
    parameter int unsigned COLUMNS = DEF_COLUMNS,
    parameter int unsigned ROWS    = DEF_ROWS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_q_empty,
    input  wire logic [COLOR_W-1:0] i_fg_color,
    input  wire logic [COLOR_W-1:0] i_bg_color,
    input  wire logic               i_out_stall,
    output logic                    o_pop,
    output logic                    o_ready,
    output logic                    o_out_valid,
    output t_result                 o_out_data
);

    localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
    localparam int unsigned MOVE_COUNT = COLUMNS * (ROWS - 1);
    localparam int unsigned AW         = $clog2(CELL_COUNT);
    localparam int unsigned CW         = $clog2(COLUMNS);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_PRIME  = 3'd4;
    localparam logic [2:0] S_SCROLL = 3'd5;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] n_cnt;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [AW-1:0] r_base;
    logic [AW-1:0] n_base;
    logic          r_out_vld;
    logic          n_out_vld;
    t_result       r_out;
    t_result       n_out;

    logic [CHAR_W*2-1:0] w_blank;
    logic [CHAR_W-1:0]   w_attr;
    logic                w_take;
    logic                w_out_free;
    logic                w_last_cnt;
    logic                w_in_range;
    logic [CW:0]         w_step_col;
    logic                w_wrap;
    logic                w_row_inc;
    logic                w_last_row;
    logic [CW-1:0]       w_put_col;
    logic [AW-1:0]       w_put_base;
    logic [AW-1:0]       w_cur_addr;
    logic                w_ram_we;
    logic [AW-1:0]       w_ram_waddr;
    logic [CELL_W-1:0]   w_ram_wdata;
    logic [AW-1:0]       w_ram_raddr;
    logic [CELL_W-1:0]   w_ram_rdata;

    function automatic logic [OFFSET_W-1:0] offset_of(
        input logic [AW-1:0] base,
        input logic [CW-1:0] col
    );
        logic [AW-1:0] sum;
        sum = base + AW'(col);
        return OFFSET_W'(sum);
    endfunction

    assign w_attr     = {i_bg_color, i_fg_color};
    assign w_blank    = {w_attr, CH_SPACE};
    assign w_take     = r_out_vld && !i_out_stall;
    assign w_out_free = !r_out_vld || w_take;
    assign w_last_cnt = (r_cnt == AW'(CELL_COUNT - 1));
    assign w_in_range = {{(32 - CELL_INDEX_W){1'b0}}, i_cmd.cell_index} < 32'(CELL_COUNT);
    assign w_cur_addr = r_base + AW'(r_col);
    assign w_last_row = (r_base == AW'(MOVE_COUNT));

    always_comb begin
        case (i_cmd.op) inside
            OP_PRINT: w_step_col = {1'b0, r_col} + (CW + 1)'(1);
            OP_TAB:   w_step_col = {1'b0, r_col} + (CW + 1)'(TAB_STEP);
            OP_NEWLINE, OP_RETURN: w_step_col = '0;
            default:  w_step_col = {1'b0, r_col};
        endcase
    end

    assign w_wrap     = (w_step_col >= (CW + 1)'(COLUMNS));
    assign w_row_inc  = (i_cmd.op == OP_NEWLINE) || w_wrap;
    assign w_put_col  = w_wrap ? '0 : w_step_col[CW-1:0];
    assign w_put_base = (w_row_inc && !w_last_row) ? r_base + AW'(COLUMNS) : r_base;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_base      = r_base;
        n_out_vld   = w_take ? 1'b0 : r_out_vld;
        n_out       = r_out;
        o_pop       = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_cnt;
        w_ram_wdata = w_blank;
        w_ram_raddr = AW'(i_cmd.cell_index);
        unique case (r_state)
            S_INIT: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = RESET_CELL;
                n_cnt       = w_last_cnt ? '0 : r_cnt + AW'(1);
                if (w_last_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty && w_out_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op) inside
                        OP_READ: begin
                            if (w_in_range) begin
                                n_state = S_READ;
                            end else begin
                                n_out_vld = 1'b1;
                                n_out     = '{cursor_offset: offset_of(r_base, r_col),
                                              cell_value: '0};
                            end
                        end
                        OP_CLEAR: begin
                            n_state = S_CLEAR;
                            n_cnt   = '0;
                            n_col   = '0;
                            n_base  = '0;
                        end
                        default: begin
                            w_ram_we    = (i_cmd.op == OP_PRINT);
                            w_ram_waddr = w_cur_addr;
                            w_ram_wdata = {w_attr, i_cmd.char_code};
                            n_col       = w_put_col;
                            n_base      = w_put_base;
                            if (w_row_inc && w_last_row) begin
                                n_state = S_PRIME;
                            end else begin
                                n_out_vld = 1'b1;
                                n_out     = '{cursor_offset: offset_of(w_put_base, w_put_col),
                                              cell_value: '0};
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state   = S_IDLE;
                n_out_vld = 1'b1;
                n_out     = '{cursor_offset: offset_of(r_base, r_col), cell_value: w_ram_rdata};
            end
            S_CLEAR: begin
                w_ram_we = 1'b1;
                n_cnt    = w_last_cnt ? '0 : r_cnt + AW'(1);
                if (w_last_cnt) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_out     = '{cursor_offset: offset_of(r_base, r_col), cell_value: '0};
                end
            end
            S_PRIME: begin
                w_ram_raddr = AW'(COLUMNS);
                n_cnt       = '0;
                n_state     = S_SCROLL;
            end
            S_SCROLL: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = (r_cnt < AW'(MOVE_COUNT)) ? w_ram_rdata : w_blank;
                w_ram_raddr = r_cnt + AW'(COLUMNS + 1);
                n_cnt       = w_last_cnt ? '0 : r_cnt + AW'(1);
                if (w_last_cnt) begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_out     = '{cursor_offset: offset_of(r_base, r_col), cell_value: '0};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cnt     <= '0;
            r_col     <= '0;
            r_base    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_col     <= n_col;
            r_base    <= n_base;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_ready     = (r_state != S_INIT);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[rtl/text_console_writer_core.sv]
// ============================================================================
// text_console_writer_core: text-mode console engine
// Put character, clear screen and read cell over a COLUMNS x ROWS cell store.
// ============================================================================
// After reset the block runs a clearing pass over all COLUMNS*ROWS cells
// that writes a white-on-black space to every cell, and holds its
// input stalled until that pass is done; color writes are taken meanwhile.
// The input side buffers up to two beats ahead of the engine. The engine
// starts an item only when the result register is empty or its waiting
// result is taken in that same cycle, so a stalled output holds the engine.
// In the engine, a put that does not scroll, an unused kind and a read past
// the end of the store finish in the idle state; a read goes on to the read
// state, a clear writes every cell in turn, and a scrolling put primes a
// read and then moves the rows up. Every beat in gives exactly one beat
// out, holding the cursor offset after the item and, for a read, the cell.
// ============================================================================
`default_nettype none

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int unsigned COLUMNS = DEF_COLUMNS,
    parameter int unsigned ROWS    = DEF_ROWS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire t_item                  i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output t_result                     o_out_data,
    input  wire logic                   i_out_stall,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [COLOR_W-1:0]     i_cfg_data
);

    localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

    logic [COLOR_W-1:0] r_fg_color;
    logic [COLOR_W-1:0] r_bg_color;
    logic               w_push;
    logic               w_pop;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_engine_ready;
    t_cmd               w_front_cmd;
    t_cmd               w_queue_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color <= FG_RESET;
            r_bg_color <= BG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FG_COLOR: r_fg_color <= i_cfg_data;
                REG_BG_COLOR: r_bg_color <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcw_front u_front (
        .i_in_valid     (i_in_valid),
        .i_item         (i_in_data),
        .i_q_full       (w_q_full),
        .i_engine_ready (w_engine_ready),
        .o_in_stall     (o_in_stall),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_queue_cmd),
        .i_q_empty   (w_q_empty),
        .i_fg_color  (r_fg_color),
        .i_bg_color  (r_bg_color),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_ready     (w_engine_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_init_stall: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("Input accepted right after reset, before the clearing pass.");

    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("Command pushed into a full queue.");

    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!w_q_empty && w_engine_ready))
        else $error("Command popped from an empty queue or during the clearing pass.");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((CELL_COUNT > 2048) ||
                         (32'(o_out_data.cursor_offset) < 32'(CELL_COUNT))))
        else $error("Cursor offset beyond the cell store.");

endmodule

`default_nettype wire
